// ===== rtl/kmd_pkg.sv =====
// Shared types, constants and helpers for the key matrix debounce and note encoder.
package kmd_pkg;

   localparam int KEY_W      = 64;
   localparam int WAIT_W     = 16;
   localparam int GAP_W      = 8;
   localparam int NOTE_W     = 7;
   localparam int VEL_W      = 7;
   localparam int HDR_W      = 4;
   localparam int STATUS_W   = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam int REQ_DATA_W = 72;
   localparam int RSP_DATA_W = 32;

   localparam int NUM_KEYS_DEF = 32;
   localparam int COLUMNS_DEF  = 8;
   localparam int ROWS_DEF     = 8;

   localparam logic [WAIT_W-1:0] WAIT_RESET     = 16'd1000;
   localparam logic [GAP_W-1:0]  GAP_RESET      = 8'd100;
   localparam logic [NOTE_W-1:0] BASE_RESET     = 7'h3C;
   localparam logic [VEL_W-1:0]  VEL_RESET      = 7'h7F;
   localparam logic [STATUS_W-1:0] STATUS_ON    = 8'h90;
   localparam logic [STATUS_W-1:0] STATUS_OFF   = 8'h80;
   localparam logic [HDR_W-1:0]  HDR_ON         = 4'h9;
   localparam logic [HDR_W-1:0]  HDR_OFF        = 4'h8;
   localparam logic [1:0]        ALL_SAMPLES    = 2'd3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DEBOUNCE_WAIT = 2'd0,
      CSR_SAMPLE_GAP    = 2'd1,
      CSR_BASE_NOTE     = 2'd2,
      CSR_ON_VELOCITY   = 2'd3
   } csr_index_type;

   // Result of the unanimous three-sample compare for one tick.
   typedef struct packed {
      logic             update;
      logic [KEY_W-1:0] press;
      logic [KEY_W-1:0] release_mask;
   } change_type;

   // Message chosen by the note queue for one tick.
   typedef struct packed {
      logic              emit;
      logic              note_on;
      logic [NOTE_W-1:0] note;
   } emit_type;

   // Matrix bits that exist for the given column and row counts.
   function automatic logic [KEY_W-1:0] used_mask(input int cols, input int rows);
      logic [KEY_W-1:0] m;
      m = '0;
      for (int c = 0; c < 8; c++) begin
         for (int r = 0; r < 8; r++) begin
            if (c < cols && r < rows) begin
               m[c*8 + r] = 1'b1;
            end
         end
      end
      return m;
   endfunction

endpackage

// ===== rtl/kmd_debounce.sv =====
// Triple-sample unanimous debounce with wait and gap counters and the stable key image.
module kmd_debounce import kmd_pkg::*; #(
   parameter int COLUMNS = COLUMNS_DEF,
   parameter int ROWS    = ROWS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic [KEY_W-1:0]  key_matrix,
   input  logic [WAIT_W-1:0] debounce_wait,
   input  logic [GAP_W-1:0]  sample_gap,
   output change_type        change
);

   localparam logic [KEY_W-1:0] USED = used_mask(COLUMNS, ROWS);

   logic [KEY_W-1:0]  sample_a_ff, sample_a_in;
   logic [KEY_W-1:0]  sample_b_ff, sample_b_in;
   logic [KEY_W-1:0]  sample_c_ff, sample_c_in;
   logic [KEY_W-1:0]  stable_ff, stable_in;
   logic [WAIT_W-1:0] wait_ff, wait_in;
   logic [GAP_W-1:0]  gap_ff, gap_in;
   logic [1:0]        taken_ff, taken_in;

   logic [KEY_W-1:0]  snap;
   logic [KEY_W-1:0]  diff;
   logic [1:0]        taken_now;
   logic              take;
   logic              agree;

   always_comb begin
      snap      = key_matrix & USED;
      take      = (wait_ff >= debounce_wait) && (gap_ff == '0);
      sample_a_in = sample_a_ff;
      sample_b_in = sample_b_ff;
      sample_c_in = sample_c_ff;
      taken_now = taken_ff;
      if (take) begin
         case (taken_ff)
            2'd0: sample_a_in = snap;
            2'd1: sample_b_in = snap;
            2'd2: sample_c_in = snap;
            default: ;
         endcase
         if (taken_ff != ALL_SAMPLES) begin
            taken_now = taken_ff + 2'd1;
         end
      end

      agree = (taken_now == ALL_SAMPLES) && (sample_a_in == sample_b_in) &&
              (sample_b_in == sample_c_in) && (sample_a_in != stable_ff);
      diff  = sample_a_in ^ stable_ff;
      stable_in = agree ? sample_b_in : stable_ff;

      change.update       = agree;
      change.press        = diff & sample_a_in;
      change.release_mask = diff & ~sample_a_in;

      // The window stays open once the count reaches the register value.
      taken_in = taken_now;
      wait_in  = wait_ff;
      if (wait_ff < debounce_wait) begin
         wait_in = wait_ff + WAIT_W'(1);
      end else if (taken_now == ALL_SAMPLES) begin
         wait_in  = '0;
         taken_in = '0;
      end
      if (wait_in >= debounce_wait && gap_ff < sample_gap) begin
         gap_in = gap_ff + GAP_W'(1);
      end else begin
         gap_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_a_ff <= '1;
         sample_b_ff <= '1;
         sample_c_ff <= '1;
         stable_ff   <= '1;
         wait_ff     <= '0;
         gap_ff      <= '0;
         taken_ff    <= '0;
      end else if (advance) begin
         sample_a_ff <= sample_a_in;
         sample_b_ff <= sample_b_in;
         sample_c_ff <= sample_c_in;
         stable_ff   <= stable_in;
         wait_ff     <= wait_in;
         gap_ff      <= gap_in;
         taken_ff    <= taken_in;
      end
   end

   // A new stable image only ever comes from a completed, unanimous sample set.
   assert property (@(posedge clock) disable iff (reset)
      (advance && change.update) |=> (stable_ff == sample_b_ff))
      else $error("stable image differs from the agreed sample");

endmodule

// ===== rtl/kmd_note_queue.sv =====
// Per-key pending press/release marks and the round-robin emit pointer.
module kmd_note_queue import kmd_pkg::*; #(
   parameter int NUM_KEYS = NUM_KEYS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic              host_ready,
   input  change_type        change,
   input  logic [NOTE_W-1:0] base_note,
   output emit_type          event_out
);

   localparam int PTR_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
   localparam logic [PTR_W:0] LAST_KEY = (PTR_W + 1)'(NUM_KEYS - 1);

   logic [NUM_KEYS-1:0] press_ff, press_in;
   logic [NUM_KEYS-1:0] release_ff, release_in;
   logic [PTR_W-1:0]    ptr_ff, ptr_in;

   logic [NUM_KEYS-1:0] press_now;
   logic [NUM_KEYS-1:0] release_now;
   logic [NUM_KEYS-1:0] clear_bit;
   logic [PTR_W-1:0]    ptr_now;
   logic                hit;

   always_comb begin
      press_now   = press_ff;
      release_now = release_ff;
      ptr_now     = ptr_ff;
      // A fresh stable image marks changed keys and restarts the scan at key zero.
      if (change.update) begin
         press_now   = (press_ff & ~change.release_mask[NUM_KEYS-1:0]) |
                       change.press[NUM_KEYS-1:0];
         release_now = (release_ff & ~change.press[NUM_KEYS-1:0]) |
                       change.release_mask[NUM_KEYS-1:0];
         ptr_now     = '0;
      end

      hit       = host_ready && (press_now[ptr_now] || release_now[ptr_now]);
      clear_bit = hit ? (NUM_KEYS'(1) << ptr_now) : '0;
      press_in   = press_now & ~clear_bit;
      release_in = release_now & ~clear_bit;

      if ({1'b0, ptr_now} < LAST_KEY) begin
         ptr_in = ptr_now + PTR_W'(1);
      end else begin
         ptr_in = '0;
      end

      event_out.emit    = hit;
      event_out.note_on = press_now[ptr_now];
      event_out.note    = base_note + NOTE_W'(ptr_now);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         press_ff   <= '0;
         release_ff <= '0;
         ptr_ff     <= '0;
      end else if (advance) begin
         press_ff   <= press_in;
         release_ff <= release_in;
         ptr_ff     <= ptr_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      (press_ff & release_ff) == '0)
      else $error("key marked for press and release at once");

   assert property (@(posedge clock) disable iff (reset)
      {1'b0, ptr_ff} <= LAST_KEY)
      else $error("emit pointer beyond the last key");

endmodule

// ===== rtl/key_matrix_debounce_midi_events.sv =====
// A tick is held in the input register, and its message is registered on rsp when the tick advances.
// Throughput: one tick per cycle; a message waiting on rsp_tready holds the next tick and req.
// A tick that yields no message produces no output transaction.
// Reset (synchronous, active high) loads the registers with their defaults, sets the
// samples and stable image to all pressed, clears pending marks, pointer and counters.
module key_matrix_debounce_midi_events import kmd_pkg::*; #(
   parameter int NUM_KEYS = NUM_KEYS_DEF,
   parameter int COLUMNS  = COLUMNS_DEF,
   parameter int ROWS     = ROWS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // key_matrix [63:0], host_ready [64], zero [71:65]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // event_valid [0], packet_header [4:1], status_byte [12:5], note_number [19:13],
   // velocity [26:20], zero [31:27]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  csr_index_type         csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [WAIT_W-1:0] wait_cfg_ff;
   logic [GAP_W-1:0]  gap_cfg_ff;
   logic [NOTE_W-1:0] base_cfg_ff;
   logic [VEL_W-1:0]  vel_cfg_ff;

   logic              in_valid_ff;
   logic [KEY_W-1:0]  in_keys_ff;
   logic              in_ready_ff;

   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic       advance;
   change_type change;
   emit_type   event_now;

   assign csr_ready  = 1'b1;
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wait_cfg_ff <= WAIT_RESET;
         gap_cfg_ff  <= GAP_RESET;
         base_cfg_ff <= BASE_RESET;
         vel_cfg_ff  <= VEL_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_DEBOUNCE_WAIT: wait_cfg_ff <= csr_wdata;
            CSR_SAMPLE_GAP:    gap_cfg_ff  <= csr_wdata[GAP_W-1:0];
            CSR_BASE_NOTE:     base_cfg_ff <= csr_wdata[NOTE_W-1:0];
            CSR_ON_VELOCITY:   vel_cfg_ff  <= csr_wdata[VEL_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tvalid && req_tready) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_keys_ff  <= req_tdata[KEY_W-1:0];
         in_ready_ff <= req_tdata[KEY_W];
      end
   end

   kmd_debounce #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_debounce (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .key_matrix    (in_keys_ff),
      .debounce_wait (wait_cfg_ff),
      .sample_gap    (gap_cfg_ff),
      .change        (change)
   );

   kmd_note_queue #(
      .NUM_KEYS (NUM_KEYS)
   ) u_note_queue (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .host_ready (in_ready_ff),
      .change     (change),
      .base_note  (base_cfg_ff),
      .event_out  (event_now)
   );

   always_comb begin
      rsp_data_in        = '0;
      rsp_data_in[0]     = 1'b1;
      rsp_data_in[4:1]   = event_now.note_on ? HDR_ON : HDR_OFF;
      rsp_data_in[12:5]  = event_now.note_on ? STATUS_ON : STATUS_OFF;
      rsp_data_in[19:13] = event_now.note;
      rsp_data_in[26:20] = event_now.note_on ? vel_cfg_ff : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= event_now.emit;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && event_now.emit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      (advance && event_now.emit) |=> rsp_valid_ff)
      else $error("emitted message did not reach the output register");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_data_ff[4:1] == HDR_ON) == (rsp_data_ff[12:5] == STATUS_ON)))
      else $error("packet header and status byte disagree");

endmodule
